[rtl/tnsl_pkg.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup: shared package
// Entry layout, control and status groups, and result codes used by the
// controller, the datapath and the name matcher.
// ----------------------------------------------------------------------------
package tnsl_pkg;

    // Names are carried as 12 bytes packed as {name_high, name_low}.
    localparam int NAME_BITS = 96;

    // A start address of all ones marks the end of the table.
    localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;

    // Result status codes.
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_WRITTEN = 2'd3;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] byte_size;
        logic [31:0] entry_flags;
        logic [31:0] alignment;
        logic [31:0] load_address;
        logic [63:0] name_low;
        logic [31:0] name_high;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       wr_en;
        logic       rd_en;
        logic       emit;
        logic [1:0] status;
        logic [3:0] found_index;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_empty;
        logic hit;
        logic end_mark;
    } t_stat;

endpackage

[rtl/toc_name_substring_lookup.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup
// Holds a table of entries and finds the first entry whose name contains a
// key name as a substring.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising clock edge where start is high and busy is
// low. With i_mode low the item writes one whole entry to slot
// i_entry_index; a slot beyond the table writes nothing. With i_mode high the
// item is a query whose key is the name fields, ending at its first zero byte.
// Every item gives one result, shown on the o_ ports for a single cycle while
// o_done is high. The receiver cannot hold results off and must take each one
// in the cycle it is shown; busy may already be low in that cycle.
// Timing: a load item, or a query with an empty key, gives its result without
// a scan. Otherwise the scan reads the entry memory one slot per cycle, a rate
// set by the single read port of the entry memory, and stops at the first end
// mark or hit, or at the last slot of the table.
// The next item may be taken in the cycle its predecessor's result shows.
// Reset clears the controller and marks every slot as unwritten, so the table
// reads as empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module toc_name_substring_lookup import tnsl_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NAME_BYTES    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_start_address,
    input  logic [31:0] i_byte_size,
    input  logic [31:0] i_entry_flags,
    input  logic [31:0] i_alignment,
    input  logic [31:0] i_load_address,
    input  logic [63:0] i_name_low,
    input  logic [31:0] i_name_high,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_found_index,
    output logic [31:0] o_found_start,
    output logic [31:0] o_found_size,
    output logic [31:0] o_found_flags,
    output logic [31:0] o_found_alignment,
    output logic [31:0] o_found_load,
    output logic [63:0] o_found_name_low,
    output logic [31:0] o_found_name_high
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_found;

    // The controller walks the slots; the datapath holds the table and
    // evaluates the slot read in the previous cycle.
    tnsl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_mode    (i_mode),
        .i_stat    (w_stat),
        .busy      (busy),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr)
    );

    tnsl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_rd_addr       (w_rd_addr),
        .i_entry_index   (i_entry_index),
        .i_start_address (i_start_address),
        .i_byte_size     (i_byte_size),
        .i_entry_flags   (i_entry_flags),
        .i_alignment     (i_alignment),
        .i_load_address  (i_load_address),
        .i_name_low      (i_name_low),
        .i_name_high     (i_name_high),
        .o_stat          (w_stat),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found_index   (o_found_index),
        .o_found         (w_found)
    );

    // Fields other than the status read as zero unless an entry was found.
    assign o_found_start     = w_found.start_address;
    assign o_found_size      = w_found.byte_size;
    assign o_found_flags     = w_found.entry_flags;
    assign o_found_alignment = w_found.alignment;
    assign o_found_load      = w_found.load_address;
    assign o_found_name_low  = w_found.name_low;
    assign o_found_name_high = w_found.name_high;

endmodule

[rtl/tnsl_match.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup: substring matcher
// Checks whether an entry name holds the key at any byte offset, all offsets
// compared in parallel. Also flags an empty key.
// ----------------------------------------------------------------------------
module tnsl_match import tnsl_pkg::*; #(
    parameter int NAME_BYTES = 12
) (
    input  logic [NAME_BITS-1:0] i_key,
    input  logic [NAME_BITS-1:0] i_name,
    output logic                 o_key_empty,
    output logic                 o_hit
);

    logic [7:0]            key_b    [NAME_BYTES];
    logic [7:0]            name_ext [2*NAME_BYTES];
    logic [NAME_BYTES-1:0] key_on;
    logic [NAME_BYTES-1:0] name_pre;
    logic [NAME_BYTES-1:0] off_hit;

    always_comb begin
        for (int k = 0; k < NAME_BYTES; k++) begin
            key_b[k]               = i_key[8*k +: 8];
            name_ext[k]            = i_name[8*k +: 8];
            name_ext[NAME_BYTES+k] = 8'd0;
        end

        // A key byte takes part only while no zero byte has come before it.
        key_on[0] = (key_b[0] != 8'd0);
        for (int k = 1; k < NAME_BYTES; k++) begin
            key_on[k] = key_on[k-1] && (key_b[k] != 8'd0);
        end

        // An offset is usable only if the name has not ended before it.
        name_pre[0] = 1'b1;
        for (int o = 1; o < NAME_BYTES; o++) begin
            name_pre[o] = name_pre[o-1] && (name_ext[o-1] != 8'd0);
        end

        // Key bytes are nonzero, so the zero padding past the name end makes
        // any placement that runs off the name fail.
        for (int o = 0; o < NAME_BYTES; o++) begin
            off_hit[o] = name_pre[o];
            for (int k = 0; k < NAME_BYTES; k++) begin
                if (key_on[k] && (name_ext[o+k] != key_b[k])) begin
                    off_hit[o] = 1'b0;
                end
            end
        end
    end

    assign o_key_empty = !key_on[0];
    assign o_hit       = key_on[0] && (|off_hit);

endmodule

[rtl/tnsl_ctrl.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup: controller
// Sequences load items and the slot-by-slot scan of a query.
// ----------------------------------------------------------------------------
module tnsl_ctrl import tnsl_pkg::*; #(
    parameter  int TABLE_ENTRIES = 16,
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     i_mode,
    input  t_stat                    i_stat,
    output logic                     busy,
    output t_cmd                     o_cmd,
    output logic [IDX_W-1:0]         o_rd_addr
);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_KEY  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cmp, n_cmp;

    always_comb begin
        n_state   = r_state;
        n_cmp     = r_cmp;
        o_cmd     = '0;
        o_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_mode == MODE_LOAD) ? S_LOAD : S_KEY;
                end
            end
            S_LOAD: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_WRITTEN;
                n_state      = S_IDLE;
            end
            S_KEY: begin
                if (i_stat.key_empty) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_cmp       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.end_mark) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_MISS;
                    n_state      = S_IDLE;
                end else if (i_stat.hit) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.status      = ST_FOUND;
                    o_cmd.found_index = 4'(r_cmp);
                    n_state           = S_IDLE;
                end else if (r_cmp == LAST_SLOT) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_MISS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_cmp + IDX_W'(1);
                    n_cmp       = r_cmp + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmp   <= '0;
        end else begin
            r_state <= n_state;
            r_cmp   <= n_cmp;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[rtl/tnsl_dp.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup: datapath
// Item capture, the entry memory with its written flags, the name matcher
// and the result registers.
// ----------------------------------------------------------------------------
module tnsl_dp import tnsl_pkg::*; #(
    parameter  int TABLE_ENTRIES = 16,
    parameter  int NAME_BYTES    = 12,
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [IDX_W-1:0]   i_rd_addr,
    input  logic [3:0]         i_entry_index,
    input  logic [31:0]        i_start_address,
    input  logic [31:0]        i_byte_size,
    input  logic [31:0]        i_entry_flags,
    input  logic [31:0]        i_alignment,
    input  logic [31:0]        i_load_address,
    input  logic [63:0]        i_name_low,
    input  logic [31:0]        i_name_high,
    output t_stat              o_stat,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [3:0]         o_found_index,
    output t_entry             o_found
);

    logic [3:0]             r_index;
    t_entry                 r_item;
    t_entry                 r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_valid;
    logic                   r_done;
    logic [1:0]             r_status;
    logic [3:0]             r_found_index;
    t_entry                 r_found;

    logic [IDX_W+3:0]       w_idx_ext;
    logic [IDX_W-1:0]       w_wr_addr;
    logic                   w_wr_ok;
    logic                   w_hit;
    logic                   w_key_empty;

    assign w_idx_ext = (IDX_W + 4)'(r_index);
    assign w_wr_addr = w_idx_ext[IDX_W-1:0];
    assign w_wr_ok   = ({28'd0, r_index} < 32'(TABLE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_index               <= i_entry_index;
            r_item.start_address  <= i_start_address;
            r_item.byte_size      <= i_byte_size;
            r_item.entry_flags    <= i_entry_flags;
            r_item.alignment      <= i_alignment;
            r_item.load_address   <= i_load_address;
            r_item.name_low       <= i_name_low;
            r_item.name_high      <= i_name_high;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_wr_ok) begin
            r_mem[w_wr_addr] <= r_item;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Slots never written read as end of table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en && w_wr_ok) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    tnsl_match #(
        .NAME_BYTES (NAME_BYTES)
    ) u_match (
        .i_key       ({r_item.name_high, r_item.name_low}),
        .i_name      ({r_rd_data.name_high, r_rd_data.name_low}),
        .o_key_empty (w_key_empty),
        .o_hit       (w_hit)
    );

    assign o_stat.key_empty = w_key_empty;
    assign o_stat.hit       = w_hit;
    assign o_stat.end_mark  = !r_rd_valid || (r_rd_data.start_address == END_MARK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            if (i_cmd.status == ST_FOUND) begin
                r_found_index <= i_cmd.found_index;
                r_found       <= r_rd_data;
            end else begin
                r_found_index <= '0;
                r_found       <= '0;
            end
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = r_found_index;
    assign o_found       = r_found;

endmodule

[tb/sv/toc_name_substring_lookup_tb.sv]
// ----------------------------------------------------------------------------
// Table-of-contents name lookup: self-checking testbench
// Loads table entries and searches them by name through the start/busy
// command port. An internal table copy predicts each status and returned
// entry, and every strobed result is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module toc_name_substring_lookup_tb;
    import tnsl_pkg::*;

    // One item as it is driven onto the command ports. For a query only the
    // name fields matter; the other fields still carry random values.
    typedef struct packed {
        logic       mode;
        logic [3:0] index;
        t_entry     ent;
    } t_item;

    // One result as it appears on the o_ ports.
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] index;
        t_entry     ent;
    } t_result;

    // A predicted result, tagged with the cycle in which its item was taken.
    typedef struct {
        t_result res;
        int      taken_cycle;
    } t_pending_result;

    localparam int SLOTS       = 16;
    localparam int RANDOM_ITEMS = 1000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_item       drive_item = '0;

    logic        busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [3:0]  o_found_index;
    logic [31:0] o_found_start;
    logic [31:0] o_found_size;
    logic [31:0] o_found_flags;
    logic [31:0] o_found_alignment;
    logic [31:0] o_found_load;
    logic [63:0] o_found_name_low;
    logic [31:0] o_found_name_high;

    // Items waiting to be driven, and the results still to come back.
    t_item           pending_items[$];
    t_pending_result expected_results[$];

    // Table copy used for prediction; it follows the items as they are taken.
    t_entry toc_model [SLOTS];

    // Shadow of the table as it stands at generation time. Items run in the
    // order they are queued, so this tells the generator which names are live
    // when each query executes.
    logic [31:0] gen_start [SLOTS];
    logic [95:0] gen_name  [SLOTS];

    int cycle_count = 0;
    int n_sent      = 0;
    int n_errors    = 0;
    int n_found     = 0;
    int n_miss      = 0;
    int n_empty     = 0;
    int n_written   = 0;
    int idle_pct    = 0;

    t_item           next_item;
    t_pending_result taken;
    t_result         got;
    t_pending_result want;

    toc_name_substring_lookup DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (drive_item.mode),
        .i_entry_index     (drive_item.index),
        .i_start_address   (drive_item.ent.start_address),
        .i_byte_size       (drive_item.ent.byte_size),
        .i_entry_flags     (drive_item.ent.entry_flags),
        .i_alignment       (drive_item.ent.alignment),
        .i_load_address    (drive_item.ent.load_address),
        .i_name_low        (drive_item.ent.name_low),
        .i_name_high       (drive_item.ent.name_high),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_found_index     (o_found_index),
        .o_found_start     (o_found_start),
        .o_found_size      (o_found_size),
        .o_found_flags     (o_found_flags),
        .o_found_alignment (o_found_alignment),
        .o_found_load      (o_found_load),
        .o_found_name_low  (o_found_name_low),
        .o_found_name_high (o_found_name_high)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Name handling. A name is 12 bytes packed as {name_high, name_low}, byte
    // k at bits 8k+7..8k. Its length runs to the first zero byte; the bytes
    // after that take no part in any comparison.
    // ------------------------------------------------------------------------
    function automatic int name_length(logic [95:0] nm);
        int len;
        bit ended;
        len   = 0;
        ended = 1'b0;
        for (int k = 0; k < 12; k++) begin
            if (nm[8*k +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                len++;
        end
        return len;
    endfunction

    // True when the key, klen bytes long, appears anywhere inside the
    // terminated part of the entry name. A name shorter than the key never
    // holds it.
    function automatic bit name_holds_key(logic [95:0] nm, logic [95:0] key, int klen);
        int  nlen;
        bit  same;
        nlen = name_length(nm);
        if (nlen < klen)
            return 1'b0;
        for (int off = 0; off + klen <= nlen; off++) begin
            same = 1'b1;
            for (int k = 0; k < klen; k++) begin
                if (nm[8*(off+k) +: 8] != key[8*k +: 8])
                    same = 1'b0;
            end
            if (same)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Works out the result of one taken item and applies a load to the
    // table copy. The scan walks the slots in order and stops at the first
    // end mark, so it never goes past a slot that was not written.
    function automatic t_result predict_lookup(t_item it);
        t_result     r;
        logic [95:0] key;
        int          klen;
        bit          stop;
        r = '0;
        if (it.mode == MODE_LOAD) begin
            toc_model[it.index] = it.ent;
            r.status = ST_WRITTEN;
        end else begin
            key  = {it.ent.name_high, it.ent.name_low};
            klen = name_length(key);
            if (klen == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_MISS;
                stop     = 1'b0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!stop) begin
                        if (toc_model[s].start_address == END_MARK) begin
                            stop = 1'b1;
                        end else if (name_holds_key({toc_model[s].name_high,
                                                     toc_model[s].name_low},
                                                    key, klen)) begin
                            r.status = ST_FOUND;
                            r.index  = s[3:0];
                            r.ent    = toc_model[s];
                            stop     = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. An item is taken at an edge where start is high and busy is
    // low; the prediction is made right there from the item on the ports.
    // While an item waits for busy to drop it is held unchanged. Otherwise a
    // new item is put up unless the sender idles this cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                taken.res         = predict_lookup(drive_item);
                taken.taken_cycle = cycle_count;
                expected_results.push_back(taken);
                n_sent++;
            end
            if (!start || !busy) begin
                // Idling phases of 125 items each: none, heavy, light.
                case ((n_sent / 125) % 3)
                    0:       idle_pct = 0;
                    1:       idle_pct = 74;
                    default: idle_pct = 10;
                endcase
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    next_item = pending_items.pop_front();
                    drive_item <= next_item;
                    start      <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each strobed result is taken at the edge that ends its cycle
    // and checked against the oldest prediction. A prediction made at this
    // very edge belongs to an item just taken and cannot be answered yet.
    // ------------------------------------------------------------------------
    task automatic compare_result(t_result exp_r, t_result act_r);
        if (act_r.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, act_r.status);
            n_errors++;
        end
        if (act_r.index !== exp_r.index) begin
            $error("found_index: expected %0d, got %0d", exp_r.index, act_r.index);
            n_errors++;
        end
        if (act_r.ent.start_address !== exp_r.ent.start_address) begin
            $error("found_start: expected %h, got %h",
                   exp_r.ent.start_address, act_r.ent.start_address);
            n_errors++;
        end
        if (act_r.ent.byte_size !== exp_r.ent.byte_size) begin
            $error("found_size: expected %h, got %h",
                   exp_r.ent.byte_size, act_r.ent.byte_size);
            n_errors++;
        end
        if (act_r.ent.entry_flags !== exp_r.ent.entry_flags) begin
            $error("found_flags: expected %h, got %h",
                   exp_r.ent.entry_flags, act_r.ent.entry_flags);
            n_errors++;
        end
        if (act_r.ent.alignment !== exp_r.ent.alignment) begin
            $error("found_alignment: expected %h, got %h",
                   exp_r.ent.alignment, act_r.ent.alignment);
            n_errors++;
        end
        if (act_r.ent.load_address !== exp_r.ent.load_address) begin
            $error("found_load: expected %h, got %h",
                   exp_r.ent.load_address, act_r.ent.load_address);
            n_errors++;
        end
        if (act_r.ent.name_low !== exp_r.ent.name_low) begin
            $error("found_name_low: expected %h, got %h",
                   exp_r.ent.name_low, act_r.ent.name_low);
            n_errors++;
        end
        if (act_r.ent.name_high !== exp_r.ent.name_high) begin
            $error("found_name_high: expected %h, got %h",
                   exp_r.ent.name_high, act_r.ent.name_high);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got.status            = o_status;
            got.index             = o_found_index;
            got.ent.start_address = o_found_start;
            got.ent.byte_size     = o_found_size;
            got.ent.entry_flags   = o_found_flags;
            got.ent.alignment     = o_found_alignment;
            got.ent.load_address  = o_found_load;
            got.ent.name_low      = o_found_name_low;
            got.ent.name_high     = o_found_name_high;
            if (expected_results.size() == 0 ||
                expected_results[0].taken_cycle == cycle_count) begin
                $error("result with status %0d arrived with no item outstanding",
                       o_status);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                compare_result(want.res, got);
                case (want.res.status)
                    ST_FOUND:   n_found++;
                    ST_MISS:    n_miss++;
                    ST_EMPTY:   n_empty++;
                    default:    n_written++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [95:0] text_name(string s);
        logic [95:0] nm;
        nm = '0;
        for (int k = 0; k < s.len() && k < 12; k++)
            nm[8*k +: 8] = s[k];
        return nm;
    endfunction

    function automatic logic [95:0] random_bits96();
        return {$urandom, $urandom, $urandom};
    endfunction

    // Mostly random words, with the two extremes showing up often.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Entry names lean on a three-letter alphabet so that queries hit often;
    // some carry arbitrary bytes, and the bytes after the terminator are
    // frequently junk that must be stored but never compared.
    function automatic logic [95:0] random_entry_name();
        logic [95:0] nm;
        int          len;
        if ($urandom_range(0, 19) == 0)
            return random_bits96();
        len = $urandom_range(0, 12);
        nm  = $urandom_range(0, 1) ? random_bits96() : '0;
        for (int k = 0; k < len; k++)
            nm[8*k +: 8] = ($urandom_range(0, 99) < 80) ? 8'(8'h61 + $urandom_range(0, 2))
                                                        : 8'($urandom_range(1, 255));
        if (len < 12)
            nm[8*len +: 8] = 8'h00;
        return nm;
    endfunction

    function automatic logic [95:0] random_short_key();
        logic [95:0] key;
        int          len;
        len = $urandom_range(1, 4);
        key = random_bits96();
        for (int k = 0; k < len; k++)
            key[8*k +: 8] = 8'(8'h61 + $urandom_range(0, 2));
        key[8*len +: 8] = 8'h00;
        return key;
    endfunction

    // A key cut out of the name held in a live slot, so that the query is sure to
    // find something at or before that slot; an empty name gets a random short key.
    function automatic logic [95:0] substring_key(int slot);
        logic [95:0] nm;
        logic [95:0] key;
        int          nlen;
        int          off;
        int          klen;
        nm   = gen_name[slot];
        nlen = name_length(nm);
        if (nlen == 0)
            return random_short_key();
        off  = $urandom_range(0, nlen - 1);
        klen = $urandom_range(1, nlen - off);
        key  = random_bits96();
        for (int k = 0; k < klen; k++)
            key[8*k +: 8] = nm[8*(off+k) +: 8];
        if (klen < 12)
            key[8*klen +: 8] = 8'h00;
        return key;
    endfunction

    // Number of slots ahead of the first end mark in the generator's shadow.
    function automatic int live_slots();
        for (int s = 0; s < SLOTS; s++) begin
            if (gen_start[s] == END_MARK)
                return s;
        end
        return SLOTS;
    endfunction

    task automatic queue_load(input logic [3:0] slot, input logic [31:0] st,
                              input logic [31:0] sz, input logic [31:0] fl,
                              input logic [31:0] al, input logic [31:0] ld,
                              input logic [95:0] nm);
        t_item it;
        it.mode              = MODE_LOAD;
        it.index             = slot;
        it.ent.start_address = st;
        it.ent.byte_size     = sz;
        it.ent.entry_flags   = fl;
        it.ent.alignment     = al;
        it.ent.load_address  = ld;
        it.ent.name_low      = nm[63:0];
        it.ent.name_high     = nm[95:64];
        gen_start[slot]      = st;
        gen_name[slot]       = nm;
        pending_items.push_back(it);
    endtask

    // The fields a query does not use still get random values.
    task automatic queue_query(input logic [95:0] key);
        t_item it;
        it.mode              = MODE_QUERY;
        it.index             = 4'($urandom_range(0, 15));
        it.ent.start_address = $urandom;
        it.ent.byte_size     = $urandom;
        it.ent.entry_flags   = $urandom;
        it.ent.alignment     = $urandom;
        it.ent.load_address  = $urandom;
        it.ent.name_low      = key[63:0];
        it.ent.name_high     = key[95:64];
        pending_items.push_back(it);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed items, random items, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        int          slot;
        int          live;
        int          pick;
        int          drain_cycles;
        logic [31:0] st;
        logic [95:0] garbage_key;

        for (int s = 0; s < SLOTS; s++) begin
            toc_model[s]               = '0;
            toc_model[s].start_address = END_MARK;
            gen_start[s]               = END_MARK;
            gen_name[s]                = '0;
        end

        // Query on the empty table, then an empty key whose upper bytes are
        // junk: it must report an empty key without scanning.
        queue_query(text_name("boot"));
        queue_query({32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00});

        // Slot 0 with all-zero fields, slot 1 with all-ones fields but a start address
        // one below the end mark, and a name that fills all twelve bytes.
        queue_load(4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, text_name("boot"));
        queue_load(4'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, text_name("kernel_image"));
        queue_query(text_name("oot"));
        queue_query(text_name("kernel_image"));

        // A key longer than the name in slot 0 skips that entry.
        queue_query(text_name("bootx"));

        // Junk after the key's terminator plays no part in the match.
        garbage_key = text_name("boot");
        garbage_key[95:40] = 56'hA5_5A_FF_80_01_7E_C3;
        queue_query(garbage_key);

        // Junk stored after an entry's terminator comes back unchanged.
        queue_load(4'd2, 32'd100, 32'h1234_5678, 32'h8000_0001, 32'h0000_1000,
                   32'hDEAD_BEEF, {32'hFFFF_FFFF, 64'hC3C3_C3C3_FF00_6261});
        queue_query(text_name("ab"));

        // Fill the table to its last slot; the scan must then run off the end.
        for (int s = 3; s < SLOTS; s++)
            queue_load(s[3:0], 32'h1000 * s, $urandom, $urandom, $urandom, $urandom,
                       (s == SLOTS - 1) ? text_name("last_slot") : text_name("zq"));
        queue_query(text_name("last"));
        queue_query(text_name("zzz"));

        // An end mark written into slot 1 hides every later slot.
        queue_load(4'd1, END_MARK, 32'h0, 32'h0, 32'h0, 32'h0, text_name("kernel"));
        queue_query(text_name("ab"));

        // Random part: mostly loads that grow the table and queries built
        // from live names, with end marks, empty keys and raw bytes mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            live = live_slots();
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 99) < 60 && live < SLOTS)
                    slot = live;
                else
                    slot = $urandom_range(0, SLOTS - 1);
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    st = END_MARK;
                else if (pick < 12)
                    st = 32'h0;
                else
                    st = $urandom;
                queue_load(slot[3:0], st, random_word(), random_word(), random_word(),
                           random_word(), random_entry_name());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55 && live > 0)
                    queue_query(substring_key($urandom_range(0, live - 1)));
                else if (pick < 70)
                    queue_query(random_short_key());
                else if (pick < 80)
                    queue_query(random_bits96() << 8);
                else
                    queue_query(random_bits96());
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item has been taken, then for its result.
        while (pending_items.size() != 0 || start)
            @(posedge i_clk);
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < 200) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        // A few more cycles to catch any stray strobe.
        repeat (24) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end

        $display("Checked %0d items: %0d writes, %0d hits, %0d misses, %0d empty keys.",
                 n_sent, n_written, n_found, n_miss, n_empty);
        $display("Sender idling cycled through none, heavy and light phases.");
        if (n_errors == 0) begin
            $display("toc_name_substring_lookup_tb: clean");
        end else begin
            $display("toc_name_substring_lookup_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #1_000_000;
        $display("toc_name_substring_lookup_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/tnsl_pkg.sv
rtl/tnsl_match.sv
rtl/tnsl_ctrl.sv
rtl/tnsl_dp.sv
rtl/toc_name_substring_lookup.sv
tb/sv/toc_name_substring_lookup_tb.sv
